/* hdl/pmc_pkg.sv */
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared types, constants and the clamp function of the mouse cursor block.
// ----------------------------------------------------------------------------
package pmc_pkg;

  localparam int COORD_WIDTH = 12;
  localparam int LIMIT_W     = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CALC_W      = ((COORD_WIDTH > LIMIT_W) ? COORD_WIDTH : LIMIT_W) + 2;

  localparam int PKT_DEPTH   = 2;
  localparam int PKT_PTR_W   = $clog2(PKT_DEPTH);
  localparam int PKT_CNT_W   = $clog2(PKT_DEPTH + 1);
  localparam int OUT_DEPTH   = 2;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  localparam logic [7:0] AUX_MARK = 8'h08;
  localparam logic [7:0] LEFT_BIT = 8'h01;

  localparam logic [LIMIT_W-1:0]     RESET_XLIM = LIMIT_W'(309);
  localparam logic [LIMIT_W-1:0]     RESET_YLIM = LIMIT_W'(184);
  localparam logic [COORD_WIDTH-1:0] RESET_X    = COORD_WIDTH'(160);
  localparam logic [COORD_WIDTH-1:0] RESET_Y    = COORD_WIDTH'(100);

  localparam logic signed [CALC_W-1:0] COORD_MAX = CALC_W'((1 << COORD_WIDTH) - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_LIMIT = 2'd0,
    REG_Y_LIMIT = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic       left;
    logic [7:0] dx;
    logic [7:0] dy;
  } pkt_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic                   left;
  } res_t;

  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic empty;
  } pkt_q_ctl_t;

  function automatic logic [COORD_WIDTH-1:0] clamp_coord(
    input logic signed [CALC_W-1:0] v,
    input logic [LIMIT_W-1:0]       limit
  );
    logic signed [CALC_W-1:0] lim;
    logic signed [CALC_W-1:0] r;
    lim = signed'({{(CALC_W-LIMIT_W){1'b0}}, limit});
    if (lim > COORD_MAX) begin
      lim = COORD_MAX;
    end
    r = v;
    if (r < 0) begin
      r = '0;
    end else if (r > lim) begin
      r = lim;
    end
    return r[COORD_WIDTH-1:0];
  endfunction

endpackage

/* hdl/pmc_front.sv */
// ----------------------------------------------------------------------------
// pmc_front
// Byte classifier: filters out non-aux bytes, aligns packets and emits whole packets.
// ----------------------------------------------------------------------------
module pmc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic          in_from_aux,
  input  logic [7:0]    in_data_byte,
  input  logic          pkt_full,
  output logic          pkt_push,
  output pmc_pkg::pkt_t pkt_data
);

  typedef enum logic [2:0] {
    ST_IDX0 = 3'b001,
    ST_IDX1 = 3'b010,
    ST_IDX2 = 3'b100
  } idx_state_t;

  idx_state_t state_r, state_nxt;
  logic       left_r, left_nxt;
  logic [7:0] dx_r, dx_nxt;
  logic       take;

  assign in_full = pkt_full;
  assign take    = in_push && !pkt_full && in_from_aux;

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    dx_nxt    = dx_r;
    pkt_push  = 1'b0;
    if (take) begin
      unique case (state_r)
        ST_IDX0: begin
          if ((in_data_byte & pmc_pkg::AUX_MARK) != 8'h00) begin
            left_nxt  = (in_data_byte & pmc_pkg::LEFT_BIT) != 8'h00;
            state_nxt = ST_IDX1;
          end
        end
        ST_IDX1: begin
          dx_nxt    = in_data_byte;
          state_nxt = ST_IDX2;
        end
        ST_IDX2: begin
          pkt_push  = 1'b1;
          state_nxt = ST_IDX0;
        end
        default: state_nxt = ST_IDX0;
      endcase
    end
  end

  assign pkt_data.left = left_r;
  assign pkt_data.dx   = dx_r;
  assign pkt_data.dy   = in_data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDX0;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    dx_r   <= dx_nxt;
  end

endmodule

/* hdl/pmc_pkt_fifo.sv */
// ----------------------------------------------------------------------------
// pmc_pkt_fifo
// Short packet queue between the byte classifier and the cursor update.
// ----------------------------------------------------------------------------
module pmc_pkt_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pmc_pkg::pkt_t wr_data,
  output logic          full,
  input  logic          pop,
  output pmc_pkg::pkt_t rd_data,
  output logic          empty
);

  pmc_pkg::pkt_t                     mem_r [pmc_pkg::PKT_DEPTH];
  logic [pmc_pkg::PKT_PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [pmc_pkg::PKT_CNT_W-1:0]     count_r;
  logic                              do_wr, do_rd;

  assign full    = count_r == pmc_pkg::PKT_CNT_W'(pmc_pkg::PKT_DEPTH);
  assign empty   = count_r == '0;
  assign do_wr   = push && !full;
  assign do_rd   = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == pmc_pkg::PKT_PTR_W'(pmc_pkg::PKT_DEPTH - 1)) ? '0
                    : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == pmc_pkg::PKT_PTR_W'(pmc_pkg::PKT_DEPTH - 1)) ? '0
                    : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hdl/pmc_back.sv */
// ----------------------------------------------------------------------------
// pmc_back
// Cursor update: applies packet motion, clamps, and queues the results.
// ----------------------------------------------------------------------------
module pmc_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [pmc_pkg::LIMIT_W-1:0]     x_limit,
  input  logic [pmc_pkg::LIMIT_W-1:0]     y_limit,
  input  logic                            pkt_empty,
  input  pmc_pkg::pkt_t                   pkt_data,
  output logic                            pkt_pop,
  input  logic                            out_pop,
  output logic                            out_empty,
  output logic [pmc_pkg::COORD_WIDTH-1:0] out_cursor_x,
  output logic [pmc_pkg::COORD_WIDTH-1:0] out_cursor_y,
  output logic                            out_left_button
);

  localparam int CW = pmc_pkg::CALC_W;
  localparam int W  = pmc_pkg::COORD_WIDTH;

  logic [W-1:0]                  pos_x_r, pos_x_nxt;
  logic [W-1:0]                  pos_y_r, pos_y_nxt;
  logic signed [CW-1:0]          nx, ny;
  pmc_pkg::res_t                 mem_r [pmc_pkg::OUT_DEPTH];
  pmc_pkg::res_t                 res;
  logic [pmc_pkg::OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [pmc_pkg::OUT_CNT_W-1:0] count_r;
  logic                          do_rd;

  assign out_empty = count_r == '0;
  assign do_rd     = out_pop && !out_empty;
  assign pkt_pop   = !pkt_empty &&
                     ((count_r != pmc_pkg::OUT_CNT_W'(pmc_pkg::OUT_DEPTH)) || do_rd);

  always_comb begin
    nx = signed'({{(CW-W){1'b0}}, pos_x_r}) + signed'({{(CW-8){pkt_data.dx[7]}}, pkt_data.dx});
    ny = signed'({{(CW-W){1'b0}}, pos_y_r}) - signed'({{(CW-8){pkt_data.dy[7]}}, pkt_data.dy});
    pos_x_nxt = pmc_pkg::clamp_coord(nx, x_limit);
    pos_y_nxt = pmc_pkg::clamp_coord(ny, y_limit);
    res.x     = pos_x_nxt;
    res.y     = pos_y_nxt;
    res.left  = pkt_data.left;
  end

  assign out_cursor_x    = mem_r[rd_ptr_r].x;
  assign out_cursor_y    = mem_r[rd_ptr_r].y;
  assign out_left_button = mem_r[rd_ptr_r].left;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r  <= pmc_pkg::RESET_X;
      pos_y_r  <= pmc_pkg::RESET_Y;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (pkt_pop) begin
        pos_x_r  <= pos_x_nxt;
        pos_y_r  <= pos_y_nxt;
        wr_ptr_r <= (wr_ptr_r == pmc_pkg::OUT_PTR_W'(pmc_pkg::OUT_DEPTH - 1)) ? '0
                    : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == pmc_pkg::OUT_PTR_W'(pmc_pkg::OUT_DEPTH - 1)) ? '0
                    : rd_ptr_r + 1'b1;
      end
      if (pkt_pop && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !pkt_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_pop) begin
      mem_r[wr_ptr_r] <= res;
    end
  end

endmodule

/* hdl/ps2_mouse_packet_cursor.sv */
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor
// PS/2 mouse three-byte packet decoder with a clamped cursor position.
//
// Controller bytes enter through in_push/in_full with the aux flag and the
// raw byte. Bytes without the aux flag are dropped, and a packet starts
// only on a byte with bit 3 set. Each completed packet produces one item
// on the result side, read through out_empty/out_pop: clamped cursor X,
// cursor Y (screen-down positive) and the left button.
// One byte is accepted every cycle while in_full is low. The packet is
// written into the packet queue when its third byte is accepted; the
// cursor update then takes it and writes its result into the result
// queue, from which it reaches the result ports, once that queue has room.
// The x_limit and y_limit registers are written through cfg_valid/cfg_ready
// (always ready) and are meant to change only while the block is idle.
// Reset sets the cursor to (160, 100), the limits to 309 and 184, and
// empties both queues. When the receiver stalls, the result queue fills,
// then the packet queue, and then in_full rises until a result is popped.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_from_aux,
  input  logic [7:0]                        in_data_byte,
  input  logic                              out_pop,
  output logic                              out_empty,
  output logic [pmc_pkg::COORD_WIDTH-1:0]   out_cursor_x,
  output logic [pmc_pkg::COORD_WIDTH-1:0]   out_cursor_y,
  output logic                              out_left_button,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pmc_pkg::LIMIT_W-1:0]       cfg_data
);

  logic [pmc_pkg::LIMIT_W-1:0] x_limit_r, y_limit_r;
  pmc_pkg::pkt_q_ctl_t         pq;
  pmc_pkg::pkt_t               pkt_wr, pkt_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= pmc_pkg::RESET_XLIM;
      y_limit_r <= pmc_pkg::RESET_YLIM;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == pmc_pkg::REG_X_LIMIT) begin
        x_limit_r <= cfg_data;
      end else if (cfg_index == pmc_pkg::REG_Y_LIMIT) begin
        y_limit_r <= cfg_data;
      end
    end
  end

  pmc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_from_aux  (in_from_aux),
    .in_data_byte (in_data_byte),
    .pkt_full     (pq.full),
    .pkt_push     (pq.push),
    .pkt_data     (pkt_wr)
  );

  pmc_pkt_fifo u_pkt_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (pq.push),
    .wr_data (pkt_wr),
    .full    (pq.full),
    .pop     (pq.pop),
    .rd_data (pkt_rd),
    .empty   (pq.empty)
  );

  pmc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .x_limit         (x_limit_r),
    .y_limit         (y_limit_r),
    .pkt_empty       (pq.empty),
    .pkt_data        (pkt_rd),
    .pkt_pop         (pq.pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_cursor_x    (out_cursor_x),
    .out_cursor_y    (out_cursor_y),
    .out_left_button (out_left_button)
  );

  a_pkt_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pq.push && pq.full))
    else $error("packet pushed into a full queue");

  a_pkt_from_aux: assert property (@(posedge clk) disable iff (!rst_n)
    pq.push |-> (in_push && !in_full && in_from_aux))
    else $error("packet emitted without an accepted aux byte");

  a_result_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(pq.pop))
    else $error("result appeared without a packet being taken");

endmodule
